[design/bdq_pkg.sv]
// Shared codes, state type and default sizes for the bounded deque.
package bdq_pkg;

	localparam int DEPTH_DEFAULT     = 16;
	localparam int WORD_BITS_DEFAULT = 32;

	localparam int KIND_BITS   = 3;
	localparam int STATUS_BITS = 2;

	localparam logic [KIND_BITS-1:0] KIND_PUSH_FRONT = 3'd0;
	localparam logic [KIND_BITS-1:0] KIND_PUSH_BACK  = 3'd1;
	localparam logic [KIND_BITS-1:0] KIND_POP_FRONT  = 3'd2;
	localparam logic [KIND_BITS-1:0] KIND_POP_BACK   = 3'd3;
	localparam logic [KIND_BITS-1:0] KIND_DUMP       = 3'd4;

	localparam logic [STATUS_BITS-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_BITS-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STATUS_BITS-1:0] STAT_FULL  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP_RD,
		ST_DUMP
	} state_t;

endpackage

[design/bounded_deque_with_dump_core.sv]
// Top level of the bounded double-ended queue with dump.
// Requests enter on the slave stream: tuser carries the kind (push front, push back,
// pop front, pop back, dump) and tdata the word to push. Results leave on the master
// stream: tuser carries the status (ok, empty, full), tdata the popped or dumped word
// (zero otherwise) and tlast marks the final result of a request. Words sit in a ring
// inside one synchronous RAM with a registered read. A push or any request answered
// without a RAM read is registered directly; a pop reads the RAM, then registers the
// result; a dump reads the RAM once per word, paced by the output. A request
// register in front lets the next transaction be taken while a result waits. Unused
// kind codes are dropped without a result. The RAM needs no clearing after reset.
module bounded_deque_with_dump_core #(
	parameter int DEPTH     = bdq_pkg::DEPTH_DEFAULT,
	parameter int WORD_BITS = bdq_pkg::WORD_BITS_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [((WORD_BITS+7)/8)*8-1:0]       s_tdata,   // push_value
	input  logic [bdq_pkg::KIND_BITS-1:0]        s_tuser,   // kind
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [((WORD_BITS+7)/8)*8-1:0]       m_tdata,   // word_out
	output logic [bdq_pkg::STATUS_BITS-1:0]      m_tuser,   // status
	output logic                                 m_tlast    // last_of_run
);

	localparam int AW = $clog2(DEPTH);
	localparam int DW = ((WORD_BITS+7)/8)*8;

	function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
			input logic [AW:0] off);
		logic [AW:0] sum;
		sum = {1'b0, base} + off;
		if (sum >= (AW+1)'(DEPTH)) begin
			sum = sum - (AW+1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	// request register
	logic                           req_valid_q;
	logic [bdq_pkg::KIND_BITS-1:0]  req_kind_q;
	logic [WORD_BITS-1:0]           req_value_q;

	// ring state
	logic [AW-1:0]  front_q, front_d;
	logic [AW:0]    occ_q, occ_d;
	logic [AW-1:0]  rd_ptr_q, rd_ptr_d;
	logic [AW:0]    rem_q, rem_d;
	bdq_pkg::state_t state_q, state_d;

	// output register
	logic                             o_valid_q;
	logic [bdq_pkg::STATUS_BITS-1:0]  o_status_q;
	logic [WORD_BITS-1:0]             o_word_q;
	logic                             o_last_q;

	logic                             o_load;
	logic [bdq_pkg::STATUS_BITS-1:0]  o_status_d;
	logic [WORD_BITS-1:0]             o_word_d;
	logic                             o_last_d;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic                 ram_re;
	logic [AW-1:0]        ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;

	logic out_free;
	logic is_full;
	logic is_empty;
	logic req_take;

	assign out_free = !o_valid_q || m_tready;
	assign is_full  = (occ_q == (AW+1)'(DEPTH));
	assign is_empty = (occ_q == '0);
	assign req_take = req_valid_q && out_free && (state_q == bdq_pkg::ST_IDLE);
	assign s_tready = !req_valid_q || req_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			req_valid_q <= 1'b1;
		end else if (req_take) begin
			req_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_kind_q  <= s_tuser;
			req_value_q <= s_tdata[WORD_BITS-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bdq_pkg::ST_IDLE: begin
				if (req_take) begin
					if ((req_kind_q == bdq_pkg::KIND_POP_FRONT ||
						req_kind_q == bdq_pkg::KIND_POP_BACK) && !is_empty) begin
						state_d = bdq_pkg::ST_POP_RD;
					end else if (req_kind_q == bdq_pkg::KIND_DUMP && !is_empty) begin
						state_d = bdq_pkg::ST_DUMP;
					end
				end
			end
			bdq_pkg::ST_POP_RD: begin
				if (out_free) begin
					state_d = bdq_pkg::ST_IDLE;
				end
			end
			bdq_pkg::ST_DUMP: begin
				if (out_free && rem_q == (AW+1)'(1)) begin
					state_d = bdq_pkg::ST_IDLE;
				end
			end
			default: state_d = bdq_pkg::ST_IDLE;
		endcase
	end

	// datapath control
	always_comb begin
		front_d    = front_q;
		occ_d      = occ_q;
		rd_ptr_d   = rd_ptr_q;
		rem_d      = rem_q;
		ram_we     = 1'b0;
		ram_waddr  = front_q;
		ram_re     = 1'b0;
		ram_raddr  = front_q;
		o_load     = 1'b0;
		o_status_d = bdq_pkg::STAT_OK;
		o_word_d   = '0;
		o_last_d   = 1'b1;
		unique case (state_q)
			bdq_pkg::ST_IDLE: begin
				if (req_take) begin
					unique case (req_kind_q)
						bdq_pkg::KIND_PUSH_FRONT, bdq_pkg::KIND_PUSH_BACK: begin
							o_load = 1'b1;
							if (is_full) begin
								o_status_d = bdq_pkg::STAT_FULL;
							end else begin
								ram_we = 1'b1;
								occ_d  = occ_q + (AW+1)'(1);
								if (req_kind_q == bdq_pkg::KIND_PUSH_FRONT) begin
									front_d   = ring_add(front_q, (AW+1)'(DEPTH-1));
									ram_waddr = front_d;
								end else begin
									ram_waddr = ring_add(front_q, occ_q);
								end
							end
						end
						bdq_pkg::KIND_POP_FRONT, bdq_pkg::KIND_POP_BACK: begin
							if (is_empty) begin
								o_load     = 1'b1;
								o_status_d = bdq_pkg::STAT_EMPTY;
							end else begin
								ram_re = 1'b1;
								occ_d  = occ_q - (AW+1)'(1);
								if (req_kind_q == bdq_pkg::KIND_POP_FRONT) begin
									ram_raddr = front_q;
									front_d   = ring_add(front_q, (AW+1)'(1));
								end else begin
									ram_raddr = ring_add(front_q, occ_q - (AW+1)'(1));
								end
							end
						end
						bdq_pkg::KIND_DUMP: begin
							if (is_empty) begin
								o_load     = 1'b1;
								o_status_d = bdq_pkg::STAT_EMPTY;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = front_q;
								rd_ptr_d  = ring_add(front_q, (AW+1)'(1));
								rem_d     = occ_q;
							end
						end
						default: ;  // drop unused kinds
					endcase
				end
			end
			bdq_pkg::ST_POP_RD: begin
				if (out_free) begin
					o_load   = 1'b1;
					o_word_d = ram_rdata;
				end
			end
			bdq_pkg::ST_DUMP: begin
				if (out_free) begin
					o_load   = 1'b1;
					o_word_d = ram_rdata;
					o_last_d = (rem_q == (AW+1)'(1));
					if (rem_q != (AW+1)'(1)) begin
						// advance to the next stored word
						ram_re    = 1'b1;
						ram_raddr = rd_ptr_q;
						rd_ptr_d  = ring_add(rd_ptr_q, (AW+1)'(1));
						rem_d     = rem_q - (AW+1)'(1);
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= bdq_pkg::ST_IDLE;
			front_q  <= '0;
			occ_q    <= '0;
			rd_ptr_q <= '0;
			rem_q    <= '0;
		end else begin
			state_q  <= state_d;
			front_q  <= front_d;
			occ_q    <= occ_d;
			rd_ptr_q <= rd_ptr_d;
			rem_q    <= rem_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
		end else if (o_load) begin
			o_valid_q <= 1'b1;
		end else if (m_tready) begin
			o_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (o_load) begin
			o_status_q <= o_status_d;
			o_word_q   <= o_word_d;
			o_last_q   <= o_last_d;
		end
	end

	bdq_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (req_value_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign m_tvalid = o_valid_q;
	assign m_tdata  = DW'(o_word_q);
	assign m_tuser  = o_status_q;
	assign m_tlast  = o_last_q;

endmodule

[design/bdq_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module bdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// hold read data until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
